FILE: src/assert_macros.svh
// Assertion macros shared by the curve generator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");

`endif

FILE: src/hcpg_pkg.sv
// Package: widths, codes and shared types of the Hermite curve point generator
`timescale 1ns / 1ps

package hcpg_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_DIV    = 63;
  localparam int DIV_W      = 6;
  localparam int COORD_W    = 32;
  localparam int CNT_W      = 7;
  localparam int LIM_W      = 8;
  localparam int POS_W      = 8;
  localparam int N3_W       = $clog2(MAX_DIV * MAX_DIV * MAX_DIV + 1);
  localparam int Q_W        = FRAC_BITS + 1;
  localparam int QCNT_W     = $clog2(Q_W);
  localparam int PROD_W     = COORD_W + Q_W + 1;
  localparam int ACC_W      = COORD_W + FRAC_BITS + 4;
  localparam int NUM_COEF   = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 72;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic [N3_W-1:0]           n3_t;
  typedef logic [Q_W-1:0]            quo_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISP_X      = 3'd0,
    CFG_DISP_Y      = 3'd1,
    CFG_TAN_START_X = 3'd2,
    CFG_TAN_START_Y = 3'd3,
    CFG_TAN_END_X   = 3'd4,
    CFG_TAN_END_Y   = 3'd5,
    CFG_DIVISIONS   = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    W_F = 2'd0,
    W_G = 2'd1,
    W_H = 2'd2
  } weight_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CUBE1,
    S_CUBE2,
    S_START,
    S_PT,
    S_PT2,
    S_NUM,
    S_DWAIT,
    S_MX,
    S_MY,
    S_FIN,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic    load;
    logic    issue;
    logic    axis;
    weight_e wsel;
  } mac_ctl_t;

  typedef struct packed {
    logic             emit;
    logic             use_start;
    logic             last;
    logic [POS_W-1:0] pos;
  } emit_t;

endpackage

FILE: src/hcpg_div.sv
// Restoring divider: one quotient bit per cycle of (num << FRAC_BITS) / den, num <= den
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hcpg_div import hcpg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  n3_t   num_i,
  input  n3_t   den_i,
  output logic  busy_o,
  output quo_t  quo_o
);

  logic              busy_q, busy_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic [N3_W:0]     rem_q, rem_d;
  quo_t              quo_q, quo_d;
  logic              ge;
  logic [N3_W:0]     diff, sel;

  assign ge   = rem_q >= {1'b0, den_i};
  assign diff = rem_q - {1'b0, den_i};
  assign sel  = ge ? diff : rem_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = QCNT_W'(Q_W - 1);
      rem_d  = {1'b0, num_i};
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = {sel[N3_W-1:0], 1'b0};
      quo_d = {quo_q[Q_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

  `ASSERT_IMPL(div_rem_bound, busy_q, rem_q < {den_i, 1'b0})
  `ASSERT_NEXT(div_start_busy, start_i, busy_q && (cnt_q == QCNT_W'(Q_W - 1)))

endmodule

FILE: src/hcpg_mac.sv
// Shared multiply-accumulate unit: coefficient times basis weight into x/y accumulators
`timescale 1ns / 1ps

module hcpg_mac import hcpg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mac_ctl_t ctl_i,
  input  coord_t   start_x_i,
  input  coord_t   start_y_i,
  input  coord_t   coef_i [NUM_COEF],
  input  quo_t     wgt_i,
  output coord_t   pt_x_o,
  output coord_t   pt_y_o
);

  acc_t                     acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic                     pv_q, pv_d, pax_q, pax_d, psub_q, psub_d;
  logic [2:0]               cidx;
  coord_t                   coef_sel;
  logic signed [Q_W:0]      wgt_s;
  acc_t                     addend;

  function automatic coord_t sat_coord(input acc_t v);
    acc_t s;
    s = v >>> FRAC_BITS;
    if ((&s[ACC_W-1:COORD_W-1]) || !(|s[ACC_W-1:COORD_W-1])) begin
      return s[COORD_W-1:0];
    end else if (s[ACC_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  assign cidx  = {ctl_i.wsel, ctl_i.axis};
  assign wgt_s = $signed({1'b0, wgt_i});

  always_comb begin
    case (cidx)
      3'd0:    coef_sel = coef_i[0];
      3'd1:    coef_sel = coef_i[1];
      3'd2:    coef_sel = coef_i[2];
      3'd3:    coef_sel = coef_i[3];
      3'd4:    coef_sel = coef_i[4];
      3'd5:    coef_sel = coef_i[5];
      default: coef_sel = '0;
    endcase
  end

  assign prod_d = coef_sel * wgt_s;
  assign pv_d   = ctl_i.issue;
  assign pax_d  = ctl_i.axis;
  assign psub_d = (ctl_i.wsel == W_H);
  assign addend = acc_t'(prod_q);

  always_comb begin
    acc_x_d = acc_x_q;
    acc_y_d = acc_y_q;
    if (ctl_i.load) begin
      acc_x_d = acc_t'(start_x_i) <<< FRAC_BITS;
      acc_y_d = acc_t'(start_y_i) <<< FRAC_BITS;
    end else if (pv_q) begin
      if (pax_q) begin
        acc_y_d = psub_q ? acc_y_q - addend : acc_y_q + addend;
      end else begin
        acc_x_d = psub_q ? acc_x_q - addend : acc_x_q + addend;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_x_q <= '0;
      acc_y_q <= '0;
      prod_q  <= '0;
      pv_q    <= 1'b0;
      pax_q   <= 1'b0;
      psub_q  <= 1'b0;
    end else begin
      acc_x_q <= acc_x_d;
      acc_y_q <= acc_y_d;
      prod_q  <= prod_d;
      pv_q    <= pv_d;
      pax_q   <= pax_d;
      psub_q  <= psub_d;
    end
  end

  assign pt_x_o = sat_coord(acc_x_q);
  assign pt_y_o = sat_coord(acc_y_q);

endmodule

FILE: src/hcpg_ctrl.sv
// Sequencer: request capture, basis numerators, divider and MAC scheduling, point emission
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hcpg_ctrl import hcpg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             mode_i,
  input  coord_t           start_x_i,
  input  coord_t           start_y_i,
  input  logic [CNT_W-1:0] base_i,
  input  logic [LIM_W-1:0] limit_i,
  input  logic [DIV_W-1:0] divisions_i,
  input  logic             out_free_i,
  input  logic             div_busy_i,
  output logic             div_start_o,
  output n3_t              div_num_o,
  output n3_t              div_den_o,
  output mac_ctl_t         mac_ctl_o,
  output coord_t           start_x_o,
  output coord_t           start_y_o,
  output emit_t            emit_o
);

  state_e               state_q, state_d;
  logic                 mode_q, mode_d;
  coord_t               sx_q, sx_d, sy_q, sy_d;
  logic [POS_W-1:0]     cnt_q, cnt_d;
  logic [LIM_W-1:0]     lim_q, lim_d;
  logic [DIV_W-1:0]     n_q, n_d, i_q, i_d;
  logic [2*DIV_W-1:0]   sq_q, sq_d, ir_q, ir_d;
  n3_t                  n3_q, n3_d;
  weight_e              w_q, w_d;

  logic [DIV_W-1:0]     n_eff, rest;
  logic [DIV_W+1:0]     t3;
  logic [2*DIV_W-1:0]   sm_a;
  logic [DIV_W+1:0]     sm_b;
  logic [3*DIV_W+1:0]   sm_p;
  logic [POS_W:0]       cnt_inc;
  logic                 lim_hit, pt_last;

  always_comb begin
    if (divisions_i == '0) begin
      n_eff = DIV_W'(1);
    end else if (divisions_i > DIV_W'(MAX_DIV)) begin
      n_eff = DIV_W'(MAX_DIV);
    end else begin
      n_eff = divisions_i;
    end
  end

  assign rest    = n_q - i_q;
  assign t3      = (DIV_W+2)'(n_q) + (DIV_W+2)'({n_q, 1'b0}) - (DIV_W+2)'({i_q, 1'b0});
  assign sm_p    = sm_a * sm_b;
  assign cnt_inc = {1'b0, cnt_q} + 1'b1;
  assign lim_hit = mode_q && (cnt_inc >= {1'b0, lim_q});
  assign pt_last = (i_q == n_q) || lim_hit;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_CUBE1;
      S_CUBE1: state_d = S_CUBE2;
      S_CUBE2: state_d = (!mode_q || cnt_q == '0) ? S_START : S_PT;
      S_START: if (out_free_i) state_d = lim_hit ? S_IDLE : S_PT;
      S_PT:    state_d = S_PT2;
      S_PT2:   state_d = S_NUM;
      S_NUM:   state_d = S_DWAIT;
      S_DWAIT: if (!div_busy_i) state_d = S_MX;
      S_MX:    state_d = S_MY;
      S_MY:    state_d = (w_q == W_H) ? S_FIN : S_NUM;
      S_FIN:   state_d = S_EMIT;
      S_EMIT:  if (out_free_i) state_d = pt_last ? S_IDLE : S_PT;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o       = (state_q == S_IDLE);
    div_start_o      = (state_q == S_NUM);
    div_num_o        = sm_p[N3_W-1:0];
    div_den_o        = n3_q;
    mac_ctl_o.load   = (state_q == S_PT);
    mac_ctl_o.issue  = (state_q == S_MX) || (state_q == S_MY);
    mac_ctl_o.axis   = (state_q == S_MY);
    mac_ctl_o.wsel   = w_q;
    emit_o.emit      = ((state_q == S_START) || (state_q == S_EMIT)) && out_free_i;
    emit_o.use_start = (state_q == S_START);
    emit_o.last      = (state_q == S_START) ? lim_hit : pt_last;
    emit_o.pos       = cnt_q;
    sm_a             = '0;
    sm_b             = '0;
    unique case (state_q)
      S_CUBE1: begin
        sm_a = (2*DIV_W)'(n_q);
        sm_b = (DIV_W+2)'(n_q);
      end
      S_CUBE2: begin
        sm_a = sq_q;
        sm_b = (DIV_W+2)'(n_q);
      end
      S_PT: begin
        sm_a = (2*DIV_W)'(i_q);
        sm_b = (DIV_W+2)'(i_q);
      end
      S_PT2: begin
        sm_a = (2*DIV_W)'(i_q);
        sm_b = (DIV_W+2)'(rest);
      end
      S_NUM: begin
        case (w_q)
          W_F: begin
            sm_a = sq_q;
            sm_b = t3;
          end
          W_G: begin
            sm_a = ir_q;
            sm_b = (DIV_W+2)'(rest);
          end
          default: begin
            sm_a = sq_q;
            sm_b = (DIV_W+2)'(rest);
          end
        endcase
      end
      default: begin
        sm_a = '0;
        sm_b = '0;
      end
    endcase
  end

  // datapath
  always_comb begin
    mode_d = mode_q;
    sx_d   = sx_q;
    sy_d   = sy_q;
    cnt_d  = cnt_q;
    lim_d  = lim_q;
    n_d    = n_q;
    i_d    = i_q;
    sq_d   = sq_q;
    ir_d   = ir_q;
    n3_d   = n3_q;
    w_d    = w_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d = mode_i;
          sx_d   = start_x_i;
          sy_d   = start_y_i;
          cnt_d  = POS_W'(base_i);
          lim_d  = limit_i;
          n_d    = n_eff;
          i_d    = DIV_W'(1);
        end
      end
      S_CUBE1: sq_d = sm_p[2*DIV_W-1:0];
      S_CUBE2: n3_d = sm_p[N3_W-1:0];
      S_START: if (out_free_i) cnt_d = cnt_inc[POS_W-1:0];
      S_PT: begin
        sq_d = sm_p[2*DIV_W-1:0];
        w_d  = W_F;
      end
      S_PT2:   ir_d = sm_p[2*DIV_W-1:0];
      S_MY: begin
        case (w_q)
          W_F:     w_d = W_G;
          W_G:     w_d = W_H;
          default: w_d = W_F;
        endcase
      end
      S_EMIT: begin
        if (out_free_i) begin
          cnt_d = cnt_inc[POS_W-1:0];
          i_d   = i_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= 1'b0;
      sx_q    <= '0;
      sy_q    <= '0;
      cnt_q   <= '0;
      lim_q   <= '0;
      n_q     <= DIV_W'(1);
      i_q     <= DIV_W'(1);
      sq_q    <= '0;
      ir_q    <= '0;
      n3_q    <= N3_W'(1);
      w_q     <= W_F;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      cnt_q   <= cnt_d;
      lim_q   <= lim_d;
      n_q     <= n_d;
      i_q     <= i_d;
      sq_q    <= sq_d;
      ir_q    <= ir_d;
      n3_q    <= n3_d;
      w_q     <= w_d;
    end
  end

  assign start_x_o = sx_q;
  assign start_y_o = sy_q;

  `ASSERT_IMPL(ctrl_idx_range, state_q == S_PT, (i_q != '0) && (i_q <= n_q))
  `ASSERT_IMPL(ctrl_mac_div_idle, (state_q == S_MX) || (state_q == S_MY), !div_busy_i)

endmodule

FILE: src/hermite_curve_point_generator.sv
// Top level: configuration registers, sequencer, divider, MAC and output register
//
// Samples a cubic Hermite curve in Q15.16. Registers are written through
// cfg_we_i / cfg_idx_i / cfg_data_i (index 0..5 displacement and tangents,
// 6 division count N); write only while the block is idle.
// A request beat on s_axis (tuser = mode) gives start point, base count and
// limit. Whole-curve mode returns N+1 beats on m_axis, front mode returns
// points until the position count reaches point_limit or the curve ends;
// tlast marks the final beat of a request.
// Sequence: after a request beat is accepted the sequencer forms N^3 and then
// registers the start point beat (in front mode only when base count is 0).
// Each curve point then takes three 17-step divisions on the shared restoring
// divider (one per basis weight) plus six products through the shared
// multiplier; s_axis_tready is high only between requests.
// The output register holds a beat until it is taken; while m_axis_tready is
// low the sequencer runs ahead up to the next point and then waits.
// Reset clears the registers to zero displacement and tangents, N = 1, and
// leaves the block idle with no beat pending.
`timescale 1ns / 1ps

module hermite_curve_point_generator import hcpg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // start_x[31:0], start_y[63:32], base_count[70:64], point_limit[78:71], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // req_type
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // point_x[31:0], point_y[63:32], position[71:64]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  coord_t           disp_x_q, disp_y_q, tan_start_x_q, tan_start_y_q;
  coord_t           tan_end_x_q, tan_end_y_q;
  logic [DIV_W-1:0] divisions_q;
  coord_t           coef [NUM_COEF];

  logic             out_valid_q, out_last_q;
  coord_t           out_x_q, out_y_q;
  logic [POS_W-1:0] out_pos_q;
  logic             out_free;

  logic             div_start, div_busy;
  n3_t              div_num, div_den;
  quo_t             quo;
  mac_ctl_t         mac_ctl;
  coord_t           sx, sy, pt_x, pt_y;
  emit_t            emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_x_q      <= '0;
      disp_y_q      <= '0;
      tan_start_x_q <= '0;
      tan_start_y_q <= '0;
      tan_end_x_q   <= '0;
      tan_end_y_q   <= '0;
      divisions_q   <= DIV_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DISP_X:      disp_x_q      <= cfg_data_i;
        CFG_DISP_Y:      disp_y_q      <= cfg_data_i;
        CFG_TAN_START_X: tan_start_x_q <= cfg_data_i;
        CFG_TAN_START_Y: tan_start_y_q <= cfg_data_i;
        CFG_TAN_END_X:   tan_end_x_q   <= cfg_data_i;
        CFG_TAN_END_Y:   tan_end_y_q   <= cfg_data_i;
        CFG_DIVISIONS:   divisions_q   <= cfg_data_i[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  assign coef[0] = disp_x_q;
  assign coef[1] = disp_y_q;
  assign coef[2] = tan_start_x_q;
  assign coef[3] = tan_start_y_q;
  assign coef[4] = tan_end_x_q;
  assign coef[5] = tan_end_y_q;

  assign out_free = !out_valid_q || m_axis_tready;

  hcpg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .mode_i      (s_axis_tuser[0]),
    .start_x_i   (s_axis_tdata[31:0]),
    .start_y_i   (s_axis_tdata[63:32]),
    .base_i      (s_axis_tdata[70:64]),
    .limit_i     (s_axis_tdata[78:71]),
    .divisions_i (divisions_q),
    .out_free_i  (out_free),
    .div_busy_i  (div_busy),
    .div_start_o (div_start),
    .div_num_o   (div_num),
    .div_den_o   (div_den),
    .mac_ctl_o   (mac_ctl),
    .start_x_o   (sx),
    .start_y_o   (sy),
    .emit_o      (emit)
  );

  hcpg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  hcpg_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mac_ctl),
    .start_x_i (sx),
    .start_y_i (sy),
    .coef_i    (coef),
    .wgt_i     (quo),
    .pt_x_o    (pt_x),
    .pt_y_o    (pt_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_pos_q   <= '0;
    end else if (emit.emit) begin
      out_valid_q <= 1'b1;
      out_last_q  <= emit.last;
      out_x_q     <= emit.use_start ? sx : pt_x;
      out_y_q     <= emit.use_start ? sy : pt_y;
      out_pos_q   <= emit.pos;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_pos_q, out_y_q, out_x_q};
  assign m_axis_tlast  = out_last_q;

endmodule
